[rtl/mhc_pkg.sv]
package mhc_pkg;

   localparam int RAW_W       = 13;
   localparam int FIELD_W     = 16;
   localparam int OFFSET_W    = 15;
   localparam int EST_W       = 15;
   localparam int BEARING_W   = 9;
   localparam int CSR_W       = 16;
   localparam int CSR_INDEX_W = 3;

   localparam int AXES   = 3;
   localparam int AXIS_W = 2;

   // magnitude times q4.12 gain times q2.14 correction
   localparam int MAG_W      = RAW_W;
   localparam int MUL_A_W    = MAG_W + CSR_W;
   localparam int PROD_W     = MUL_A_W + CSR_W;
   localparam int PROD_FRAC  = 26;
   localparam int QUOT_W     = PROD_W - PROD_FRAC;
   localparam int FIX_W      = QUOT_W + 2;

   localparam int CORDIC_W             = 19;
   localparam int ANGLE_W              = 32;
   localparam int DEG_FRAC             = 22;
   localparam int ATAN_LEN             = 24;
   localparam int ATAN_INDEX_W         = 5;
   localparam int CORDIC_STEPS_DEFAULT = 16;

   localparam logic signed [ANGLE_W-1:0] HALF_TURN = 32'sd754974720;
   localparam logic signed [ANGLE_W-1:0] FULL_TURN = 32'sd1509949440;

   localparam logic [BEARING_W-1:0] BEARING_EAST  = 9'd0;
   localparam logic [BEARING_W-1:0] BEARING_NORTH = 9'd90;
   localparam logic [BEARING_W-1:0] BEARING_WEST  = 9'd180;
   localparam logic [BEARING_W-1:0] BEARING_SOUTH = 9'd270;
   localparam logic [BEARING_W-1:0] BEARING_MAX   = 9'd359;

   localparam logic signed [RAW_W-1:0] PEAK_HIGH_INIT = -13'sd4000;
   localparam logic signed [RAW_W-1:0] PEAK_LOW_INIT  = 13'sd4000;

   localparam logic [CSR_W-1:0] GAIN_RESET = 16'd4096;
   localparam logic [CSR_W-1:0] CORR_RESET = 16'd16384;

   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_FACTOR  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_X_GAIN_CORR  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_Y_GAIN_CORR  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_Z_GAIN_CORR  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_X_OFFSET     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_Y_OFFSET     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_Z_OFFSET     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_TRACK_ENABLE = 3'd7;

   typedef struct packed {
      logic              accept;
      logic              mul_first;
      logic              mul_second;
      logic              fix;
      logic              cordic_init;
      logic              cordic_step;
      logic              cordic_end;
      logic              load_out;
      logic [AXIS_W-1:0] axis;
   } mhc_cmd_type;

   typedef struct packed {
      logic bypass;
   } mhc_status_type;

   // atan(2^-i) in units of 2^-22 degree
   function automatic logic signed [ANGLE_W-1:0] atan_value(input logic [ATAN_INDEX_W-1:0] i);
      logic signed [ANGLE_W-1:0] v;
      case (i)
         5'd0:    v = 32'sd188743680;
         5'd1:    v = 32'sd111421900;
         5'd2:    v = 32'sd58872272;
         5'd3:    v = 32'sd29884485;
         5'd4:    v = 32'sd15000234;
         5'd5:    v = 32'sd7507429;
         5'd6:    v = 32'sd3754631;
         5'd7:    v = 32'sd1877430;
         5'd8:    v = 32'sd938729;
         5'd9:    v = 32'sd469366;
         5'd10:   v = 32'sd234683;
         5'd11:   v = 32'sd117342;
         5'd12:   v = 32'sd58671;
         5'd13:   v = 32'sd29335;
         5'd14:   v = 32'sd14668;
         5'd15:   v = 32'sd7334;
         5'd16:   v = 32'sd3667;
         5'd17:   v = 32'sd1833;
         5'd18:   v = 32'sd917;
         5'd19:   v = 32'sd458;
         5'd20:   v = 32'sd229;
         5'd21:   v = 32'sd115;
         5'd22:   v = 32'sd57;
         5'd23:   v = 32'sd29;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage

[rtl/mhc_ctrl.sv]
module mhc_ctrl #(
   parameter int CORDIC_STEPS = mhc_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  mhc_pkg::mhc_status_type          status,
   output mhc_pkg::mhc_cmd_type             cmd,
   output logic [$clog2(CORDIC_STEPS)-1:0]  step_index
);

   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
   localparam logic [mhc_pkg::AXIS_W-1:0] AXIS_LAST = mhc_pkg::AXIS_W'(mhc_pkg::AXES - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MUL_A  = 3'd1;
   localparam logic [2:0] S_MUL_B  = 3'd2;
   localparam logic [2:0] S_FIX    = 3'd3;
   localparam logic [2:0] S_C_INIT = 3'd4;
   localparam logic [2:0] S_C_STEP = 3'd5;
   localparam logic [2:0] S_C_END  = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   logic [2:0]                   state_ff, state_in;
   logic [mhc_pkg::AXIS_W-1:0]   axis_ff, axis_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic                         out_valid_ff, out_valid_in;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               axis_in    = '0;
               state_in   = S_MUL_A;
            end
         end
         S_MUL_A: begin
            cmd.mul_first = 1'b1;
            state_in      = S_MUL_B;
         end
         S_MUL_B: begin
            cmd.mul_second = 1'b1;
            state_in       = S_FIX;
         end
         S_FIX: begin
            cmd.fix = 1'b1;
            if (axis_ff == AXIS_LAST) begin
               state_in = S_C_INIT;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_MUL_A;
            end
         end
         S_C_INIT: begin
            cmd.cordic_init = 1'b1;
            step_in         = '0;
            state_in        = S_C_STEP;
         end
         S_C_STEP: begin
            if (status.bypass) begin
               state_in = S_C_END;
            end else begin
               cmd.cordic_step = 1'b1;
               if (step_ff == STEP_LAST) begin
                  state_in = S_C_END;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         S_C_END: begin
            cmd.cordic_end = 1'b1;
            state_in       = S_OUT;
         end
         S_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_valid_in = cmd.load_out | (out_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= '0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = out_valid_ff;
   assign step_index = step_ff;

   a_accept_starts_axis0 : assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == S_MUL_A) && (axis_ff == '0))
      else $error("accepted item does not start scaling on the first axis");

   a_load_sets_valid : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> out_valid_ff)
      else $error("loaded result not presented");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !cmd.load_out)
      else $error("pending result overwritten");

endmodule

[rtl/mhc_datapath.sv]
module mhc_datapath #(
   parameter int CORDIC_STEPS = mhc_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_write_enable,
   input  logic [mhc_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  logic [mhc_pkg::CSR_W-1:0]                 csr_write_data,
   input  logic signed [mhc_pkg::RAW_W-1:0]          req_raw_x,
   input  logic signed [mhc_pkg::RAW_W-1:0]          req_raw_y,
   input  logic signed [mhc_pkg::RAW_W-1:0]          req_raw_z,
   input  logic                                      req_restart_tracking,
   input  mhc_pkg::mhc_cmd_type                      cmd,
   input  logic [$clog2(CORDIC_STEPS)-1:0]           step_index,
   output mhc_pkg::mhc_status_type                   status,
   output logic signed [mhc_pkg::FIELD_W-1:0]        rsp_field_x,
   output logic signed [mhc_pkg::FIELD_W-1:0]        rsp_field_y,
   output logic signed [mhc_pkg::FIELD_W-1:0]        rsp_field_z,
   output logic [mhc_pkg::BEARING_W-1:0]             rsp_bearing_deg,
   output logic signed [mhc_pkg::EST_W-1:0]          rsp_offset_est_x,
   output logic signed [mhc_pkg::EST_W-1:0]          rsp_offset_est_y,
   output logic signed [mhc_pkg::EST_W-1:0]          rsp_offset_est_z,
   output logic                                      rsp_saturated
);

   localparam int RW = mhc_pkg::RAW_W;
   localparam int FW = mhc_pkg::FIELD_W;
   localparam int CW = mhc_pkg::CORDIC_W;
   localparam int AW = mhc_pkg::ANGLE_W;
   localparam int NA = mhc_pkg::AXES;

   // configuration registers
   logic [mhc_pkg::CSR_W-1:0]            gain_ff;
   logic [mhc_pkg::CSR_W-1:0]            corr_ff [NA];
   logic signed [mhc_pkg::OFFSET_W-1:0]  off_ff [NA];
   logic                                 track_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= mhc_pkg::GAIN_RESET;
         corr_ff  <= '{default: mhc_pkg::CORR_RESET};
         off_ff   <= '{default: '0};
         track_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mhc_pkg::REG_GAIN_FACTOR:  gain_ff    <= csr_write_data;
            mhc_pkg::REG_X_GAIN_CORR:  corr_ff[0] <= csr_write_data;
            mhc_pkg::REG_Y_GAIN_CORR:  corr_ff[1] <= csr_write_data;
            mhc_pkg::REG_Z_GAIN_CORR:  corr_ff[2] <= csr_write_data;
            mhc_pkg::REG_X_OFFSET:     off_ff[0]  <= csr_write_data[mhc_pkg::OFFSET_W-1:0];
            mhc_pkg::REG_Y_OFFSET:     off_ff[1]  <= csr_write_data[mhc_pkg::OFFSET_W-1:0];
            mhc_pkg::REG_Z_OFFSET:     off_ff[2]  <= csr_write_data[mhc_pkg::OFFSET_W-1:0];
            mhc_pkg::REG_TRACK_ENABLE: track_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // sample capture and peak tracking
   logic signed [RW-1:0] req_raw [NA];
   logic signed [RW-1:0] raw_ff [NA];
   logic signed [RW-1:0] peak_hi_ff [NA], peak_hi_in [NA];
   logic signed [RW-1:0] peak_lo_ff [NA], peak_lo_in [NA];

   assign req_raw[0] = req_raw_x;
   assign req_raw[1] = req_raw_y;
   assign req_raw[2] = req_raw_z;

   always_comb begin
      logic signed [RW-1:0] hi_base;
      logic signed [RW-1:0] lo_base;
      for (int a = 0; a < NA; a++) begin
         hi_base = req_restart_tracking ? mhc_pkg::PEAK_HIGH_INIT : peak_hi_ff[a];
         lo_base = req_restart_tracking ? mhc_pkg::PEAK_LOW_INIT : peak_lo_ff[a];
         peak_hi_in[a] = (track_ff && (req_raw[a] > hi_base)) ? req_raw[a] : hi_base;
         peak_lo_in[a] = (track_ff && (req_raw[a] < lo_base)) ? req_raw[a] : lo_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_hi_ff <= '{default: mhc_pkg::PEAK_HIGH_INIT};
         peak_lo_ff <= '{default: mhc_pkg::PEAK_LOW_INIT};
      end else if (cmd.accept) begin
         peak_hi_ff <= peak_hi_in;
         peak_lo_ff <= peak_lo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         raw_ff <= req_raw;
      end
   end

   // axis scaling on one shared multiplier, two passes per axis
   logic signed [RW-1:0]              raw_sel;
   logic [mhc_pkg::MAG_W-1:0]         mag;
   logic [mhc_pkg::MUL_A_W-1:0]       mul_a;
   logic [mhc_pkg::CSR_W-1:0]         mul_b;
   logic [mhc_pkg::PROD_W-1:0]        mul_p;
   logic [mhc_pkg::PROD_W-1:0]        prod_ff;

   assign raw_sel = raw_ff[cmd.axis];
   assign mag     = raw_sel[RW-1] ? mhc_pkg::MAG_W'(-raw_sel) : mhc_pkg::MAG_W'(raw_sel);
   assign mul_a   = cmd.mul_second ? prod_ff[mhc_pkg::MUL_A_W-1:0]
                                   : mhc_pkg::MUL_A_W'(mag);
   assign mul_b   = cmd.mul_second ? corr_ff[cmd.axis] : gain_ff;
   assign mul_p   = mhc_pkg::PROD_W'(mul_a) * mhc_pkg::PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      if (cmd.mul_first || cmd.mul_second) begin
         prod_ff <= mul_p;
      end
   end

   logic signed [mhc_pkg::FIX_W-1:0] quot_s;
   logic signed [mhc_pkg::FIX_W-1:0] signed_q;
   logic signed [mhc_pkg::FIX_W-1:0] sum_q;
   logic signed [FW-1:0]             clip_val;
   logic                             clip;
   logic signed [FW-1:0]             field_ff [NA];
   logic                             sat_ff;

   assign quot_s   = $signed({2'b00, prod_ff[mhc_pkg::PROD_W-1:mhc_pkg::PROD_FRAC]});
   assign signed_q = raw_sel[RW-1] ? -quot_s : quot_s;
   assign sum_q    = signed_q + mhc_pkg::FIX_W'(off_ff[cmd.axis]);

   always_comb begin
      clip     = 1'b0;
      clip_val = sum_q[FW-1:0];
      if (sum_q > mhc_pkg::FIX_W'(32767)) begin
         clip     = 1'b1;
         clip_val = 16'sh7FFF;
      end else if (sum_q < -mhc_pkg::FIX_W'(32768)) begin
         clip     = 1'b1;
         clip_val = 16'sh8000;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sat_ff <= 1'b0;
      end else if (cmd.fix) begin
         sat_ff <= sat_ff | clip;
      end
      if (cmd.fix) begin
         field_ff[cmd.axis] <= clip_val;
      end
   end

   // vectoring cordic, one micro-rotation per cycle
   logic signed [CW-1:0]              fx_e, fy_e;
   logic signed [CW-1:0]              x_ff, y_ff;
   logic signed [AW-1:0]              ang_ff;
   logic signed [CW-1:0]              xs, ys;
   logic signed [AW-1:0]              atan_v;
   logic                              bypass_ff;
   logic [mhc_pkg::BEARING_W-1:0]     bypass_deg_ff;
   logic [mhc_pkg::BEARING_W-1:0]     bypass_deg;
   logic [mhc_pkg::BEARING_W-1:0]     bearing_ff;
   logic signed [AW-1:0]              ang_wrap1, ang_wrap2;
   logic [AW-mhc_pkg::DEG_FRAC-1:0]   deg_whole;
   logic [mhc_pkg::BEARING_W-1:0]     deg_final;

   assign fx_e   = CW'(field_ff[0]);
   assign fy_e   = CW'(field_ff[1]);
   assign xs     = x_ff >>> step_index;
   assign ys     = y_ff >>> step_index;
   assign atan_v = mhc_pkg::atan_value(mhc_pkg::ATAN_INDEX_W'(step_index));

   always_comb begin
      if (fy_e == '0) begin
         bypass_deg = (fx_e < 0) ? mhc_pkg::BEARING_WEST : mhc_pkg::BEARING_EAST;
      end else begin
         bypass_deg = (fy_e > 0) ? mhc_pkg::BEARING_NORTH : mhc_pkg::BEARING_SOUTH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else if (cmd.cordic_init) begin
         bypass_ff <= (fx_e == '0) || (fy_e == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cordic_init) begin
         bypass_deg_ff <= bypass_deg;
         if (fx_e < 0) begin
            x_ff   <= -fx_e;
            y_ff   <= -fy_e;
            ang_ff <= mhc_pkg::HALF_TURN;
         end else begin
            x_ff   <= fx_e;
            y_ff   <= fy_e;
            ang_ff <= '0;
         end
      end else if (cmd.cordic_step) begin
         if (y_ff >= 0) begin
            x_ff   <= x_ff + ys;
            y_ff   <= y_ff - xs;
            ang_ff <= ang_ff + atan_v;
         end else begin
            x_ff   <= x_ff - ys;
            y_ff   <= y_ff + xs;
            ang_ff <= ang_ff - atan_v;
         end
      end
   end

   always_comb begin
      ang_wrap1 = (ang_ff < 0) ? ang_ff + mhc_pkg::FULL_TURN : ang_ff;
      ang_wrap2 = (ang_wrap1 >= mhc_pkg::FULL_TURN) ? ang_wrap1 - mhc_pkg::FULL_TURN
                                                      : ang_wrap1;
      deg_whole = (ang_wrap2 < 0) ? '0 : ang_wrap2[AW-1:mhc_pkg::DEG_FRAC];
      deg_final = (deg_whole > (AW-mhc_pkg::DEG_FRAC)'(mhc_pkg::BEARING_MAX))
                  ? mhc_pkg::BEARING_MAX : deg_whole[mhc_pkg::BEARING_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.cordic_end) begin
         bearing_ff <= bypass_ff ? bypass_deg_ff : deg_final;
      end
   end

   assign status.bypass = bypass_ff;

   // result register
   logic signed [mhc_pkg::EST_W-1:0] est [NA];

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         est[a] = -(mhc_pkg::EST_W'(peak_hi_ff[a]) + mhc_pkg::EST_W'(peak_lo_ff[a]));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_field_x      <= field_ff[0];
         rsp_field_y      <= field_ff[1];
         rsp_field_z      <= field_ff[2];
         rsp_bearing_deg  <= bearing_ff;
         rsp_offset_est_x <= est[0];
         rsp_offset_est_y <= est[1];
         rsp_offset_est_z <= est[2];
         rsp_saturated    <= sat_ff;
      end
   end

   a_sat_cleared : assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !sat_ff)
      else $error("saturation flag not cleared for new item");

   a_clip_sets_sat : assert property (@(posedge clock) disable iff (reset)
      (cmd.fix && clip) |=> sat_ff)
      else $error("clipped axis not flagged");

   a_bearing_range : assert property (@(posedge clock) disable iff (reset)
      cmd.cordic_end |=> (bearing_ff <= mhc_pkg::BEARING_MAX))
      else $error("bearing out of range");

endmodule

[rtl/magnetometer_heading_calibrator.sv]
// One raw three-axis sample in, one result out: per-axis scaled and offset fields with a
// saturation flag, the bearing in whole degrees, and the hard-iron offset estimates from the
// min/max peaks. Items are handled one at a time. Scaling uses the single shared multiplier,
// which makes two passes per axis, and the vectoring CORDIC does one micro-rotation per
// cycle; its rotations are skipped when the corrected vector lies on an axis or is zero.
// A finished result waits in an output register, so the next sample is taken while it is
// still pending. Configuration registers must only be written while no item is in flight.
module magnetometer_heading_calibrator #(
   parameter int CORDIC_STEPS = mhc_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [mhc_pkg::RAW_W-1:0]          req_raw_x,
   input  logic signed [mhc_pkg::RAW_W-1:0]          req_raw_y,
   input  logic signed [mhc_pkg::RAW_W-1:0]          req_raw_z,
   input  logic                                      req_restart_tracking,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [mhc_pkg::FIELD_W-1:0]        rsp_field_x,
   output logic signed [mhc_pkg::FIELD_W-1:0]        rsp_field_y,
   output logic signed [mhc_pkg::FIELD_W-1:0]        rsp_field_z,
   output logic [mhc_pkg::BEARING_W-1:0]             rsp_bearing_deg,
   output logic signed [mhc_pkg::EST_W-1:0]          rsp_offset_est_x,
   output logic signed [mhc_pkg::EST_W-1:0]          rsp_offset_est_y,
   output logic signed [mhc_pkg::EST_W-1:0]          rsp_offset_est_z,
   output logic                                      rsp_saturated,
   input  logic                                      csr_write_enable,
   input  logic [mhc_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  logic [mhc_pkg::CSR_W-1:0]                 csr_write_data
);

   mhc_pkg::mhc_cmd_type               cmd;
   mhc_pkg::mhc_status_type            status;
   logic [$clog2(CORDIC_STEPS)-1:0]    step_index;

   mhc_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd),
      .step_index (step_index)
   );

   mhc_datapath #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_raw_x            (req_raw_x),
      .req_raw_y            (req_raw_y),
      .req_raw_z            (req_raw_z),
      .req_restart_tracking (req_restart_tracking),
      .cmd                  (cmd),
      .step_index           (step_index),
      .status               (status),
      .rsp_field_x          (rsp_field_x),
      .rsp_field_y          (rsp_field_y),
      .rsp_field_z          (rsp_field_z),
      .rsp_bearing_deg      (rsp_bearing_deg),
      .rsp_offset_est_x     (rsp_offset_est_x),
      .rsp_offset_est_y     (rsp_offset_est_y),
      .rsp_offset_est_z     (rsp_offset_est_z),
      .rsp_saturated        (rsp_saturated)
   );

endmodule
